// ===== rtl/vlid_pkg.sv =====
package vlid_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] TypeNone = 2'd0;
  localparam logic [1:0] TypeReg  = 2'd1;
  localparam logic [1:0] TypeImm  = 2'd2;
  localparam logic [1:0] TypeMem  = 2'd3;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [1:0]  first_type;
    logic [1:0]  second_type;
    logic [23:0] first_value;
    logic [25:0] second_operand;
  } instr_t;

  function automatic logic [25:0] pack_operand(input logic [1:0] op_type,
                                               input logic [23:0] value);
    logic [25:0] result;
    result = {op_type, value};
    if (op_type == TypeNone) begin
      result = '0;
    end else if (op_type == TypeImm) begin
      result = {op_type, {8{value[15]}}, value[15:0]};
    end
    return result;
  endfunction

endpackage

// ===== rtl/vlid_front.sv =====
module vlid_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  logic [7:0]    code_byte_i,
  input  logic          cfg_we_i,
  output logic          push_o,
  output vlid_pkg::instr_t push_item_o
);
  import vlid_pkg::*;

  logic [2:0]  left_q, left_d;
  logic [4:0]  opcode_q, opcode_d;
  logic [1:0]  ft_q, ft_d;
  logic [1:0]  st_q, st_d;
  logic [23:0] acc_q, acc_d;
  logic [25:0] second_q, second_d;

  logic        accept;
  logic [1:0]  ft_dec, st_dec;
  logic [2:0]  total_dec;
  logic [23:0] acc_shift;
  logic [2:0]  left_dec;
  logic        capture;

  assign accept    = in_valid_i && !in_stall_i;
  assign ft_dec    = code_byte_i[4] ? code_byte_i[5:4] : code_byte_i[7:6];
  assign st_dec    = code_byte_i[4] ? code_byte_i[7:6] : TypeNone;
  assign total_dec = {1'b0, ft_dec} + {1'b0, st_dec};
  assign acc_shift = {acc_q[15:0], code_byte_i};
  assign left_dec  = left_q - 3'd1;
  assign capture   = (left_q > {1'b0, ft_q}) && (left_dec == {1'b0, ft_q});

  always_comb begin
    left_d      = left_q;
    opcode_d    = opcode_q;
    ft_d        = ft_q;
    st_d        = st_q;
    acc_d       = acc_q;
    second_d    = second_q;
    push_o      = 1'b0;
    push_item_o = '0;
    if (accept) begin
      if (left_q == 3'd0) begin
        opcode_d = code_byte_i[4:0];
        ft_d     = ft_dec;
        st_d     = st_dec;
        acc_d    = '0;
        second_d = '0;
        left_d   = total_dec;
        if (total_dec == 3'd0) begin
          push_o      = 1'b1;
          push_item_o = '{opcode: code_byte_i[4:0], first_type: ft_dec,
                          second_type: st_dec, first_value: '0, second_operand: '0};
        end
      end else begin
        acc_d    = capture ? '0 : acc_shift;
        second_d = capture ? pack_operand(st_q, acc_shift) : second_q;
        left_d   = left_dec;
        if (left_dec == 3'd0) begin
          push_o      = 1'b1;
          push_item_o = '{opcode: opcode_q, first_type: ft_q, second_type: st_q,
                          first_value: acc_d, second_operand: second_d};
        end
      end
    end
    if (cfg_we_i) begin
      left_d   = '0;
      opcode_d = '0;
      ft_d     = TypeNone;
      st_d     = TypeNone;
      acc_d    = '0;
      second_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      opcode_q <= '0;
      ft_q     <= TypeNone;
      st_q     <= TypeNone;
      acc_q    <= '0;
      second_q <= '0;
    end else begin
      left_q   <= left_d;
      opcode_q <= opcode_d;
      ft_q     <= ft_d;
      st_q     <= st_d;
      acc_q    <= acc_d;
      second_q <= second_d;
    end
  end

  // An instruction never spans more than six operand bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) left_q <= 3'd6)
    else $error("operand byte count out of range");

endmodule

// ===== rtl/vlid_queue.sv =====
module vlid_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vlid_pkg::instr_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output vlid_pkg::instr_t head_o
);
  import vlid_pkg::*;

  instr_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= QueueCntW'(QueueDepth))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into a full queue");

endmodule

// ===== rtl/vlid_back.sv =====
module vlid_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_start_address_i,
  input  logic             q_valid_i,
  input  vlid_pkg::instr_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [4:0]       opcode_o,
  output logic [25:0]      first_operand_o,
  output logic [25:0]      second_operand_o,
  output logic [31:0]      next_address_o
);
  import vlid_pkg::*;

  logic [31:0] ip_q, ip_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  opcode_q;
  logic [25:0] first_q, second_q;
  logic [31:0] next_q;
  logic [2:0]  step;
  logic [31:0] next_addr;

  assign q_pop_o   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign step      = {1'b0, q_head_i.first_type} + {1'b0, q_head_i.second_type} + 3'd1;
  assign next_addr = ip_q + {29'b0, step};

  always_comb begin
    out_valid_d = q_pop_o || (out_valid_q && out_stall_i);
    ip_d        = ip_q;
    if (q_pop_o) begin
      ip_d = next_addr;
    end
    if (cfg_we_i) begin
      ip_d = cfg_start_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ip_q        <= ip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      opcode_q <= q_head_i.opcode;
      first_q  <= pack_operand(q_head_i.first_type, q_head_i.first_value);
      second_q <= (q_head_i.second_type == TypeNone) ? '0 : q_head_i.second_operand;
      next_q   <= next_addr;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign opcode_o         = opcode_q;
  assign first_operand_o  = first_q;
  assign second_operand_o = second_q;
  assign next_address_o   = next_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |=> out_valid_q)
    else $error("popped instruction did not reach the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cfg_we_i |=> ip_q == $past(cfg_start_address_i))
    else $error("address counter not loaded on configuration write");

endmodule

// ===== rtl/variable_length_instruction_decoder_core.sv =====
// Byte-serial instruction decoder. It takes one code byte per cycle on the input
// channel, with no bubbles between instructions, and delivers one item per
// completed instruction: opcode, both packed operands and the address after the
// instruction. The front end assembles operand bytes and hands finished
// instructions to a two-entry queue; the back end packs them and keeps the
// address counter. A result passes through the queue and the back-end output
// register before it is presented on the output, and input stalls only when
// the queue is full because the output side is stalled. Writing the start
// address loads the address counter and discards any partly received
// instruction.
module variable_length_instruction_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_start_address_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  opcode_o,
  output logic [25:0] first_operand_o,
  output logic [25:0] second_operand_o,
  output logic [31:0] next_address_o
);
  import vlid_pkg::*;

  logic   push, full, pop, q_valid;
  instr_t push_item, q_head;

  assign in_stall_o = full;

  vlid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (full),
    .code_byte_i (code_byte_i),
    .cfg_we_i    (cfg_we_i),
    .push_o      (push),
    .push_item_o (push_item)
  );

  vlid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  vlid_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_start_address_i (cfg_start_address_i),
    .q_valid_i           (q_valid),
    .q_head_i            (q_head),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .opcode_o            (opcode_o),
    .first_operand_o     (first_operand_o),
    .second_operand_o    (second_operand_o),
    .next_address_o      (next_address_o)
  );

endmodule
